>>> hw/rtl/gap_buffer_text_store_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gap buffer text store checker
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_STORE_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_MACROS_SVH

// same-cycle implication
`define GBTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/gbts_pkg.sv
// ----------------------------------------------------------------------------
// gbts_pkg
// Types and constants shared by the gap buffer text store files.
// ----------------------------------------------------------------------------
package gbts_pkg;

    localparam int POS_W  = 13;
    localparam int BYTE_W = 8;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [2:0] {
        FUNC_SET_CURSOR = 3'd0,
        FUNC_READ       = 3'd1,
        FUNC_NEXT       = 3'd2,
        FUNC_PREV       = 3'd3,
        FUNC_INSERT     = 3'd4,
        FUNC_INSERT_ADV = 3'd5,
        FUNC_OVERWRITE  = 3'd6,
        FUNC_DELETE     = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_SATURATED = 2'd2,
        STATUS_NO_BYTE   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_MOVE,
        ST_EDIT,
        ST_LOOK,
        ST_FIN
    } state_t;

    typedef struct packed {
        byte_t   char_out;
        status_t status;
        pos_t    cursor_pos;
        pos_t    text_len;
    } rsp_t;

endpackage

>>> hw/rtl/gbts_if.sv
// ----------------------------------------------------------------------------
// gbts_if
// Command and response channels of the gap buffer text store.
// ----------------------------------------------------------------------------
interface gbts_cmd_if
    import gbts_pkg::*;
();
    logic  valid;
    logic  ready;
    func_t func;
    pos_t  position;
    byte_t char_in;
    pos_t  del_count;

    modport source (output valid, output func, output position, output char_in,
                    output del_count, input ready);
    modport sink   (input valid, input func, input position, input char_in,
                    input del_count, output ready);
endinterface

interface gbts_rsp_if
    import gbts_pkg::*;
();
    logic    valid;
    logic    ready;
    byte_t   char_out;
    status_t status;
    pos_t    cursor_pos;
    pos_t    text_len;

    modport source (output valid, output char_out, output status, output cursor_pos,
                    output text_len, input ready);
    modport sink   (input valid, input char_out, input status, input cursor_pos,
                    input text_len, output ready);
endinterface

>>> hw/rtl/gap_buffer_text_store.sv
// Flow: a taken command passes ST_PLAN, ST_EDIT, ST_LOOK and ST_FIN, then the output
//   register; an edit that first moves the gap by k bytes passes ST_MOVE before ST_EDIT,
//   where one byte is copied per cycle through the single read and single write port of the
//   byte store. cmd.ready is high only in ST_IDLE, so one command is in flight at a time.
// Reset: text empty, cursor 0; store contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Fixed-capacity gap buffer of bytes with a cursor, held in one synchronous RAM.
// ----------------------------------------------------------------------------
module gap_buffer_text_store
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096
)(
    input  logic       clk,
    input  logic       rst_n,
    gbts_cmd_if.sink   cmd,
    gbts_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int WW = (PW > POS_W) ? PW : POS_W;
    localparam logic [PW-1:0] CAP = PW'(CAPACITY);

    state_t         state_reg, state_next;
    func_t          func_reg, func_next;
    pos_t           pos_reg, pos_next;
    byte_t          char_reg, char_next;
    pos_t           count_reg, count_next;
    logic [PW-1:0]  gb_reg, gb_next;
    logic [PW-1:0]  gf_reg, gf_next;
    logic [PW-1:0]  cur_reg, cur_next;
    logic [PW-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]  src_reg, src_next;
    logic [AW-1:0]  dst_reg, dst_next;
    logic           down_reg, down_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  pend_dst_reg, pend_dst_next;
    status_t        status_reg, status_next;
    logic           has_byte_reg, has_byte_next;

    logic [PW-1:0]  gap, len, phys, rem, del;
    logic           full, cur_lt_gb, cur_lt_len, need_move, reading;

    logic           edit_we;
    logic [AW-1:0]  edit_addr;
    logic           mem_we, mem_re;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    byte_t          mem_wdata, mem_rdata;

    logic           out_in_valid, out_in_ready;
    rsp_t           out_in_data, out_data;

    assign gap        = gf_reg - gb_reg;
    assign len        = CAP - gap;
    assign full       = (gap == '0);
    assign cur_lt_gb  = cur_reg < gb_reg;
    assign cur_lt_len = cur_reg < len;
    assign phys       = cur_lt_gb ? cur_reg : cur_reg + gap;
    assign rem        = len - cur_reg;
    assign reading    = (func_reg == FUNC_READ) || (func_reg == FUNC_NEXT)
                        || (func_reg == FUNC_PREV);

    assign cmd.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            gb_reg    <= '0;
            gf_reg    <= CAP;
            cur_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gb_reg    <= gb_next;
            gf_reg    <= gf_next;
            cur_reg   <= cur_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        pos_reg      <= pos_next;
        char_reg     <= char_next;
        count_reg    <= count_next;
        cnt_reg      <= cnt_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        down_reg     <= down_next;
        pend_dst_reg <= pend_dst_next;
        status_reg   <= status_next;
        has_byte_reg <= has_byte_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        pos_next      = pos_reg;
        char_next     = char_reg;
        count_next    = count_reg;
        gb_next       = gb_reg;
        gf_next       = gf_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        down_next     = down_reg;
        pend_next     = 1'b0;
        pend_dst_next = pend_dst_reg;
        status_next   = status_reg;
        has_byte_next = has_byte_reg;
        need_move     = 1'b0;
        del           = '0;
        edit_we       = 1'b0;
        edit_addr     = gb_reg[AW-1:0];
        mem_re        = 1'b0;
        mem_raddr     = src_reg;
        out_in_valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next  = cmd.func;
                    pos_next   = cmd.position;
                    char_next  = cmd.char_in;
                    count_next = cmd.del_count;
                    state_next = ST_PLAN;
                end
            end

            ST_PLAN:
            begin
                need_move = (func_reg == FUNC_DELETE)
                    || (((func_reg == FUNC_INSERT) || (func_reg == FUNC_INSERT_ADV)) && !full)
                    || ((func_reg == FUNC_OVERWRITE) && !cur_lt_len && !full);
                state_next = ST_EDIT;
                if (need_move && (cur_reg != gb_reg))
                begin
                    // pointers jump to their final place; the copy runs on src/dst
                    gb_next = cur_reg;
                    gf_next = cur_reg + gap;
                    if (!full)
                    begin
                        state_next = ST_MOVE;
                        down_next  = cur_lt_gb;
                        if (cur_lt_gb)
                        begin
                            cnt_next = gb_reg - cur_reg;
                            src_next = AW'(gb_reg - PW'(1));
                            dst_next = AW'(gf_reg - PW'(1));
                        end
                        else
                        begin
                            cnt_next = cur_reg - gb_reg;
                            src_next = gf_reg[AW-1:0];
                            dst_next = gb_reg[AW-1:0];
                        end
                    end
                end
            end

            ST_MOVE:
            begin
                // read a source byte each cycle while bytes remain, write it in the next cycle
                if (cnt_reg != '0)
                begin
                    mem_re        = 1'b1;
                    cnt_next      = cnt_reg - PW'(1);
                    pend_next     = 1'b1;
                    pend_dst_next = dst_reg;
                    src_next      = down_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                    dst_next      = down_reg ? dst_reg - AW'(1) : dst_reg + AW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = ST_EDIT;
                end
            end

            ST_EDIT:
            begin
                status_next = STATUS_OK;
                state_next  = ST_LOOK;
                case (func_reg)
                    FUNC_SET_CURSOR:
                    begin
                        if (WW'(pos_reg) > WW'(len))
                        begin
                            cur_next    = len;
                            status_next = STATUS_SATURATED;
                        end
                        else
                        begin
                            cur_next = PW'(pos_reg);
                        end
                    end
                    FUNC_READ:
                    begin
                    end
                    FUNC_NEXT:
                    begin
                        if (!cur_lt_len)
                        begin
                            status_next = STATUS_SATURATED;
                        end
                        else
                        begin
                            cur_next = cur_reg + PW'(1);
                        end
                    end
                    FUNC_PREV:
                    begin
                        if (cur_reg == '0)
                        begin
                            status_next = STATUS_SATURATED;
                        end
                        else
                        begin
                            cur_next = cur_reg - PW'(1);
                        end
                    end
                    FUNC_INSERT, FUNC_INSERT_ADV:
                    begin
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            edit_we = 1'b1;
                            gb_next = gb_reg + PW'(1);
                            if (func_reg == FUNC_INSERT_ADV)
                            begin
                                cur_next = cur_reg + PW'(1);
                            end
                        end
                    end
                    FUNC_OVERWRITE:
                    begin
                        if (cur_lt_len)
                        begin
                            edit_we   = 1'b1;
                            edit_addr = phys[AW-1:0];
                        end
                        else if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            // append at the end, cursor stays on the new byte
                            edit_we = 1'b1;
                            gb_next = gb_reg + PW'(1);
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (WW'(count_reg) > WW'(rem))
                        begin
                            del         = rem;
                            status_next = STATUS_SATURATED;
                        end
                        else
                        begin
                            del = PW'(count_reg);
                        end
                        gf_next = gf_reg + del;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_LOOK:
            begin
                mem_re        = cur_lt_len;
                mem_raddr     = phys[AW-1:0];
                has_byte_next = cur_lt_len;
                if (reading && (status_reg == STATUS_OK) && !cur_lt_len)
                begin
                    status_next = STATUS_NO_BYTE;
                end
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                out_in_valid = 1'b1;
                if (out_in_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_we    = pend_reg || edit_we;
    assign mem_waddr = pend_reg ? pend_dst_reg : edit_addr;
    assign mem_wdata = pend_reg ? mem_rdata : char_reg;

    assign out_in_data.char_out   = has_byte_reg ? mem_rdata : '0;
    assign out_in_data.status     = status_reg;
    assign out_in_data.cursor_pos = pos_t'(cur_reg);
    assign out_in_data.text_len   = pos_t'(len);

    gbts_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    gbts_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (out_in_valid),
        .in_ready  (out_in_ready),
        .in_data   (out_in_data),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (out_data)
    );

    assign rsp.char_out   = out_data.char_out;
    assign rsp.status     = out_data.status;
    assign rsp.cursor_pos = out_data.cursor_pos;
    assign rsp.text_len   = out_data.text_len;

endmodule

>>> hw/rtl/gbts_mem.sv
// ----------------------------------------------------------------------------
// gbts_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbts_mem
    import gbts_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  byte_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output byte_t         rd_data
);

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/gbts_out_reg.sv
// ----------------------------------------------------------------------------
// gbts_out_reg
// Response output register; frees the controller while a beat waits.
// ----------------------------------------------------------------------------
module gbts_out_reg
    import gbts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rsp_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    logic valid_reg;
    rsp_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

>>> hw/rtl/gbts_checker.sv
// ----------------------------------------------------------------------------
// gbts_checker
// Port-level checks for the gap buffer text store, bound to the top level.
// ----------------------------------------------------------------------------
`include "gap_buffer_text_store_macros.svh"

module gbts_checker
    import gbts_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] char_out,
    input logic [1:0] status,
    input pos_t       cursor_pos,
    input pos_t       text_len
);

    // response beat must not drop before it is taken
    `GBTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")

    // one command in flight: busy right after taking a beat
    `GBTS_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready, !cmd_ready, "cmd taken while busy")

    `GBTS_ASSERT_NOW(a_no_byte_zero, rsp_valid && (status == STATUS_NO_BYTE), char_out == 8'd0, "no byte but char nonzero")

    // no byte at cursor only happens with the cursor at the end of the text
    `GBTS_ASSERT_NOW(a_no_byte_end, rsp_valid && (status == STATUS_NO_BYTE), cursor_pos == text_len, "no byte off end")

endmodule

bind gap_buffer_text_store gbts_checker u_gbts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .char_out   (rsp.char_out),
    .status     (rsp.status),
    .cursor_pos (rsp.cursor_pos),
    .text_len   (rsp.text_len)
);
